// File: hw/rtl/tfdt_pkg.sv
package tfdt_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 256;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam int DEPTH_W = 16;
    localparam int NUM_W   = 50;   // interpolation numerator
    localparam int DEN_W   = 32;   // determinant and weight numerators
    localparam int TEX_W   = 13;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7fff;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_VPOS0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VPOS1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VPOS2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VTEX0 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VTEX1 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VTEX2 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXW  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXH  = 4'd7;

    localparam logic OP_SHADE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE,
        S_COV,
        S_MAC,
        S_DIVGO,
        S_DIVW,
        S_TX,
        S_TY,
        S_TYW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic we;
        logic [ADDR_W-1:0] waddr;
        logic signed [DEPTH_W-1:0] wdata;
        logic re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: hw/rtl/tfdt_depth_ram.sv
module tfdt_depth_ram (
    input  logic                                 i_clk,
    input  tfdt_pkg::t_ram_req                   i_req,
    output logic signed [tfdt_pkg::DEPTH_W-1:0]  o_rdata
);

    logic signed [tfdt_pkg::DEPTH_W-1:0] r_mem [tfdt_pkg::STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

// File: hw/rtl/tfdt_div.sv
module tfdt_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tfdt_pkg::NUM_W-1:0]   i_num,
    input  logic signed [tfdt_pkg::DEN_W-1:0]   i_den,
    output logic                                o_done,
    output logic signed [tfdt_pkg::NUM_W-1:0]   o_quot
);

    localparam int NW = tfdt_pkg::NUM_W;
    localparam int DW = tfdt_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_q;
    logic [DW:0]      r_rem;
    logic [DW-1:0]    r_den;
    logic             r_neg;
    logic             r_done;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        qbit;
    logic [DW:0] n_rem;
    logic [NW-1:0] q_next;

    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_q[NW-1]};
        diff   = rem_sh - {1'b0, r_den};
        qbit   = ~diff[DW];
        n_rem  = qbit ? diff : rem_sh;
        q_next = {r_q[NW-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_den <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_neg <= i_num[NW-1] ^ i_den[DW-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= q_next;
            r_rem <= n_rem;
            if (r_cnt == CNT_W'(NW - 1)) begin
                // truncate toward zero: fix sign of magnitude quotient
                o_quot <= r_neg ? -$signed(q_next) : $signed(q_next);
            end
        end
    end

    assign o_done = r_done;

endmodule

// File: hw/rtl/triangle_fragment_depth_test_core.sv
// Triangle fragment unit with depth test.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) loads the
// three vertex positions, three texture coordinates and the texture size; write it
// only while the block is idle. Index values past the list are ignored.
// Input channel (i_in_valid/o_in_ready) takes one item: operation, pixel x and y.
// Operation 1 clears one depth entry; operation 0 shades the pixel against the
// triangle. Each item gives exactly one result on the output channel
// (o_out_valid/i_out_ready).
// One item is worked at a time, on the single shared multiplier (one product per
// cycle) and the bit-serial divider, which divides depth and, on a pass, u and v.
// The depth store is a 65536-entry RAM; after reset a clearing pass writes the
// minimum depth to every entry, one per cycle, with o_in_ready low.
// Configuration writes are taken during that pass.
// A result waits in the output register while the receiver stalls; the next item is
// accepted meanwhile and its result holds until the register frees.
module triangle_fragment_depth_test_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tfdt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tfdt_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_operation,
    input  logic [7:0]                            i_pixel_x,
    input  logic [7:0]                            i_pixel_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_out_x,
    output logic [7:0]                            o_out_y,
    output logic                                  o_covered,
    output logic                                  o_depth_passed,
    output logic signed [tfdt_pkg::DEPTH_W-1:0]   o_fragment_depth,
    output logic [tfdt_pkg::TEX_W-1:0]            o_texel_x,
    output logic [tfdt_pkg::TEX_W-1:0]            o_texel_y
);

    localparam int AW = tfdt_pkg::ADDR_W;
    localparam int NW = tfdt_pkg::NUM_W;
    localparam int DW = tfdt_pkg::DEN_W;
    localparam int TW = tfdt_pkg::TEX_W;

    // configuration
    logic [39:0] r_vpos [3];
    logic [23:0] r_vtex [3];
    logic [TW-1:0] r_tw, r_th;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vpos[i] <= '0;
                r_vtex[i] <= '0;
            end
            r_tw <= TW'(1024);
            r_th <= TW'(1024);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tfdt_pkg::CFG_VPOS0: r_vpos[0] <= i_cfg_data;
                tfdt_pkg::CFG_VPOS1: r_vpos[1] <= i_cfg_data;
                tfdt_pkg::CFG_VPOS2: r_vpos[2] <= i_cfg_data;
                tfdt_pkg::CFG_VTEX0: r_vtex[0] <= i_cfg_data[23:0];
                tfdt_pkg::CFG_VTEX1: r_vtex[1] <= i_cfg_data[23:0];
                tfdt_pkg::CFG_VTEX2: r_vtex[2] <= i_cfg_data[23:0];
                tfdt_pkg::CFG_TEXW:  r_tw <= i_cfg_data[TW-1:0];
                tfdt_pkg::CFG_TEXH:  r_th <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    logic signed [11:0] vx [3];
    logic signed [11:0] vy [3];
    logic signed [15:0] vz [3];
    logic [11:0] vu [3];
    logic [11:0] vv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vx[i] = $signed(r_vpos[i][11:0]);
            vy[i] = $signed(r_vpos[i][23:12]);
            vz[i] = $signed(r_vpos[i][39:24]);
            vu[i] = r_vtex[i][11:0];
            vv[i] = r_vtex[i][23:12];
        end
    end

    logic signed [12:0] dx1, dx2, dy1, dy2;
    assign dx1 = 13'(vx[1]) - 13'(vx[0]);
    assign dx2 = 13'(vx[2]) - 13'(vx[0]);
    assign dy1 = 13'(vy[1]) - 13'(vy[0]);
    assign dy2 = 13'(vy[2]) - 13'(vy[0]);

    // state
    tfdt_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [2:0]    r_step;
    logic [1:0]    r_attr;
    logic [7:0]    r_px, r_py;
    logic [AW-1:0] r_addr;
    logic signed [13:0] r_ax, r_by;
    logic signed [DW-1:0] r_ex, r_ey, r_det, r_n0;
    logic signed [NW-1:0] r_acc;
    logic signed [47:0] r_prod;
    logic [TW-1:0] r_u, r_v;

    logic r_cov, r_pass;
    logic signed [tfdt_pkg::DEPTH_W-1:0] r_z;
    logic [TW-1:0] r_tx, r_ty;

    logic r_oval;

    // ram and divider hookup
    tfdt_pkg::t_ram_req ram_req;
    logic signed [tfdt_pkg::DEPTH_W-1:0] ram_rdata;
    logic div_start, div_done;
    logic signed [NW-1:0] div_quot;

    tfdt_depth_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    tfdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic in_acc;
    logic onscreen;
    logic [AW-1:0] in_addr;

    assign o_in_ready = (r_state == tfdt_pkg::S_IDLE);
    assign in_acc = i_in_valid && o_in_ready;
    assign onscreen = (int'(i_pixel_x) < tfdt_pkg::SCREEN_WIDTH) &&
                      (int'(i_pixel_y) < tfdt_pkg::SCREEN_HEIGHT);
    assign in_addr = AW'(int'(i_pixel_y) * tfdt_pkg::SCREEN_WIDTH + int'(i_pixel_x));

    // coverage
    logic signed [DW-1:0] n0;
    logic covered;
    assign n0 = r_det - r_ex - r_ey;

    function automatic logic agrees(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
        return (n == '0) || (n[DW-1] == d[DW-1]);
    endfunction

    assign covered = (r_det != '0) && agrees(n0, r_det) && agrees(r_ey, r_det) &&
                     agrees(r_ex, r_det);

    // depth from divider
    logic signed [tfdt_pkg::DEPTH_W-1:0] zq;
    logic zpass;
    always_comb begin
        if (div_quot < NW'(tfdt_pkg::DEPTH_MIN)) begin
            zq = tfdt_pkg::DEPTH_MIN;
        end else if (div_quot > NW'(tfdt_pkg::DEPTH_MAX)) begin
            zq = tfdt_pkg::DEPTH_MAX;
        end else begin
            zq = div_quot[tfdt_pkg::DEPTH_W-1:0];
        end
        zpass = ram_rdata < zq;
    end

    // shared multiplier
    logic [1:0] mac_idx;
    logic signed [31:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [47:0] mul_p;

    assign mac_idx = (r_step < 3'd3) ? r_step[1:0] : 2'd0;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            tfdt_pkg::S_EDGE: begin
                case (r_step)
                    3'd0: begin mul_a = 32'(dx1);  mul_b = 16'(r_by); end
                    3'd1: begin mul_a = 32'(r_ax); mul_b = 16'(dy1);  end
                    3'd2: begin mul_a = 32'(r_ax); mul_b = 16'(dy2);  end
                    3'd3: begin mul_a = 32'(dx2);  mul_b = 16'(r_by); end
                    3'd4: begin mul_a = 32'(dx2);  mul_b = 16'(dy1);  end
                    3'd5: begin mul_a = 32'(dx1);  mul_b = 16'(dy2);  end
                    default: ;
                endcase
            end
            tfdt_pkg::S_MAC: begin
                case (mac_idx)
                    2'd0: mul_a = r_n0;
                    2'd1: mul_a = r_ey;
                    default: mul_a = r_ex;
                endcase
                case (r_attr)
                    2'd0: mul_b = vz[mac_idx];
                    2'd1: mul_b = $signed({4'b0, vu[mac_idx]});
                    default: mul_b = $signed({4'b0, vv[mac_idx]});
                endcase
            end
            tfdt_pkg::S_TX: begin
                mul_a = $signed({19'b0, r_u});
                mul_b = $signed({3'b0, r_tw});
            end
            tfdt_pkg::S_TY: begin
                mul_a = $signed({19'b0, TW'(4096) - r_v});
                mul_b = $signed({3'b0, r_th});
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // next state and control
    always_comb begin
        n_state = r_state;
        ram_req = '0;
        div_start = 1'b0;
        case (r_state)
            tfdt_pkg::S_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_clr;
                ram_req.wdata = tfdt_pkg::DEPTH_MIN;
                if (r_clr == AW'(tfdt_pkg::STORE_DEPTH - 1)) begin
                    n_state = tfdt_pkg::S_IDLE;
                end
            end
            tfdt_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (!onscreen) begin
                        n_state = tfdt_pkg::S_DONE;
                    end else if (i_operation == tfdt_pkg::OP_CLEAR) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = in_addr;
                        ram_req.wdata = tfdt_pkg::DEPTH_MIN;
                        n_state = tfdt_pkg::S_DONE;
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = in_addr;
                        n_state = tfdt_pkg::S_EDGE;
                    end
                end
            end
            tfdt_pkg::S_EDGE: begin
                if (r_step == 3'd6) begin
                    n_state = tfdt_pkg::S_COV;
                end
            end
            tfdt_pkg::S_COV: begin
                n_state = covered ? tfdt_pkg::S_MAC : tfdt_pkg::S_DONE;
            end
            tfdt_pkg::S_MAC: begin
                if (r_step == 3'd3) begin
                    n_state = tfdt_pkg::S_DIVGO;
                end
            end
            tfdt_pkg::S_DIVGO: begin
                div_start = 1'b1;
                n_state = tfdt_pkg::S_DIVW;
            end
            tfdt_pkg::S_DIVW: begin
                if (div_done) begin
                    case (r_attr)
                        2'd0: begin
                            if (zpass) begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = r_addr;
                                ram_req.wdata = zq;
                                n_state = tfdt_pkg::S_MAC;
                            end else begin
                                n_state = tfdt_pkg::S_DONE;
                            end
                        end
                        2'd1: n_state = tfdt_pkg::S_MAC;
                        default: n_state = tfdt_pkg::S_TX;
                    endcase
                end
            end
            tfdt_pkg::S_TX:  n_state = tfdt_pkg::S_TY;
            tfdt_pkg::S_TY:  n_state = tfdt_pkg::S_TYW;
            tfdt_pkg::S_TYW: n_state = tfdt_pkg::S_DONE;
            tfdt_pkg::S_DONE: begin
                if (!r_oval || i_out_ready) begin
                    n_state = tfdt_pkg::S_IDLE;
                end
            end
            default: n_state = tfdt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfdt_pkg::S_CLEAR;
            r_clr   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tfdt_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == tfdt_pkg::S_DONE && (!r_oval || i_out_ready)) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            tfdt_pkg::S_IDLE: begin
                r_px   <= i_pixel_x;
                r_py   <= i_pixel_y;
                r_addr <= in_addr;
                r_ax   <= 14'(vx[0]) - $signed({6'b0, i_pixel_x});
                r_by   <= 14'(vy[0]) - $signed({6'b0, i_pixel_y});
                r_ex   <= '0;
                r_ey   <= '0;
                r_det  <= '0;
                r_step <= '0;
                r_cov  <= 1'b0;
                r_pass <= 1'b0;
                r_z    <= '0;
                r_tx   <= '0;
                r_ty   <= '0;
            end
            tfdt_pkg::S_EDGE: begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    3'd1: r_ex  <= r_ex  + DW'(r_prod);
                    3'd2: r_ex  <= r_ex  - DW'(r_prod);
                    3'd3: r_ey  <= r_ey  + DW'(r_prod);
                    3'd4: r_ey  <= r_ey  - DW'(r_prod);
                    3'd5: r_det <= r_det + DW'(r_prod);
                    3'd6: r_det <= r_det - DW'(r_prod);
                    default: ;
                endcase
            end
            tfdt_pkg::S_COV: begin
                r_n0   <= n0;
                r_attr <= 2'd0;
                r_step <= '0;
                r_acc  <= '0;
            end
            tfdt_pkg::S_MAC: begin
                r_step <= r_step + 1'b1;
                if (r_step != 3'd0) begin
                    r_acc <= r_acc + NW'(r_prod);
                end
            end
            tfdt_pkg::S_DIVW: begin
                if (div_done) begin
                    r_step <= '0;
                    r_acc  <= '0;
                    r_attr <= r_attr + 1'b1;
                    case (r_attr)
                        2'd0: begin
                            r_cov  <= 1'b1;
                            r_z    <= zq;
                            r_pass <= zpass;
                        end
                        2'd1: begin
                            r_u <= div_quot[NW-1] ? '0 : div_quot[TW-1:0];
                        end
                        default: begin
                            if (div_quot[NW-1]) begin
                                r_v <= '0;
                            end else if (div_quot > NW'(4096)) begin
                                r_v <= TW'(4096);
                            end else begin
                                r_v <= div_quot[TW-1:0];
                            end
                        end
                    endcase
                end
            end
            tfdt_pkg::S_TY:  r_tx <= r_prod[TW+11:12];
            tfdt_pkg::S_TYW: r_ty <= r_prod[TW+11:12];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == tfdt_pkg::S_DONE && (!r_oval || i_out_ready)) begin
            o_out_x          <= r_px;
            o_out_y          <= r_py;
            o_covered        <= r_cov;
            o_depth_passed   <= r_pass;
            o_fragment_depth <= r_z;
            o_texel_x        <= r_tx;
            o_texel_y        <= r_ty;
        end
    end

    assign o_out_valid = r_oval;

endmodule

// File: hw/rtl/tfdt_checker.sv
module tfdt_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic                                  o_covered,
    input logic                                  o_depth_passed,
    input logic signed [tfdt_pkg::DEPTH_W-1:0]   o_fragment_depth,
    input logic [tfdt_pkg::TEX_W-1:0]            o_texel_x,
    input logic [tfdt_pkg::TEX_W-1:0]            o_texel_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_pass_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth_passed |-> o_covered)
        else $error("depth pass without coverage");

    a_uncov_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_covered |-> o_fragment_depth == '0)
        else $error("uncovered item carries depth");

    a_fail_notex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_depth_passed |-> o_texel_x == '0 && o_texel_y == '0)
        else $error("texel given without depth pass");

    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item taken before depth store clear");

endmodule

bind triangle_fragment_depth_test_core tfdt_checker u_tfdt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_covered        (o_covered),
    .o_depth_passed   (o_depth_passed),
    .o_fragment_depth (o_fragment_depth),
    .o_texel_x        (o_texel_x),
    .o_texel_y        (o_texel_y)
);

// File: tb/triangle_fragment_depth_test_core_tb.sv
`timescale 1ns / 100ps

module triangle_fragment_depth_test_core_tb;

    typedef struct {
        logic [7:0]                          x;
        logic [7:0]                          y;
        logic                                cov;
        logic                                passed;
        logic signed [tfdt_pkg::DEPTH_W-1:0] z;
        logic [tfdt_pkg::TEX_W-1:0]          tx;
        logic [tfdt_pkg::TEX_W-1:0]          ty;
    } t_frag;

    typedef enum int {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind                           kind;
        logic [tfdt_pkg::CFG_IDX_W-1:0]      idx;
        logic [tfdt_pkg::CFG_DATA_W-1:0]     data;
        logic                                op;
        logic [7:0]                          x;
        logic [7:0]                          y;
        bit                                  blank_exp;
    } t_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                cfg_valid;
    logic                                o_cfg_ready;
    logic [tfdt_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [tfdt_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                in_valid;
    logic                                o_in_ready;
    logic                                op;
    logic [7:0]                          px;
    logic [7:0]                          py;
    logic                                o_out_valid;
    logic                                out_ready;
    logic [7:0]                          o_out_x;
    logic [7:0]                          o_out_y;
    logic                                o_covered;
    logic                                o_depth_passed;
    logic signed [tfdt_pkg::DEPTH_W-1:0] o_fragment_depth;
    logic [tfdt_pkg::TEX_W-1:0]          o_texel_x;
    logic [tfdt_pkg::TEX_W-1:0]          o_texel_y;

    triangle_fragment_depth_test_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (op),
        .i_pixel_x        (px),
        .i_pixel_y        (py),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_covered        (o_covered),
        .o_depth_passed   (o_depth_passed),
        .o_fragment_depth (o_fragment_depth),
        .o_texel_x        (o_texel_x),
        .o_texel_y        (o_texel_y)
    );

    // shadow of the block's registers and depth buffer
    logic [39:0]              vpos [3];
    logic [23:0]              vtex [3];
    longint                   tex_w;
    longint                   tex_h;
    shortint                  zbuf [tfdt_pkg::STORE_DEPTH];

    t_frag                    frag_q [$];
    t_row                     rows [$];
    int                       errors;
    int                       n_cov;
    int                       n_pass;
    int                       n_clear;
    int                       n_seen;
    bit                       idle_en;
    bit                       hold_pending;
    int                       stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [39:0] pack_pos(int x, int y, int z);
        logic [11:0] xs;
        logic [11:0] ys;
        logic [15:0] zs;
        xs = x[11:0];
        ys = y[11:0];
        zs = z[15:0];
        return {zs, ys, xs};
    endfunction

    function automatic longint lerp(longint n0, longint n1, longint n2,
                                    longint a0, longint a1, longint a2, longint det);
        return (n0 * a0 + n1 * a1 + n2 * a2) / det;
    endfunction

    // work out one result and update the shadow depth buffer
    function automatic t_frag shade_pixel(logic o, logic [7:0] x, logic [7:0] y);
        t_frag  f;
        longint vx [3];
        longint vy [3];
        longint vz [3];
        longint vu [3];
        longint vv [3];
        longint ex, ey, det, n0, n1, n2, z, u, v, tx, ty;
        int     a;
        f = '{x, y, 1'b0, 1'b0, '0, '0, '0};
        a = int'(y) * tfdt_pkg::SCREEN_WIDTH + int'(x);
        if (o == tfdt_pkg::OP_CLEAR) begin
            zbuf[a] = -32768;
            return f;
        end
        for (int i = 0; i < 3; i++) begin
            vx[i] = longint'($signed(vpos[i][11:0]));
            vy[i] = longint'($signed(vpos[i][23:12]));
            vz[i] = longint'($signed(vpos[i][39:24]));
            vu[i] = longint'(vtex[i][11:0]);
            vv[i] = longint'(vtex[i][23:12]);
        end
        ex = (vx[1] - vx[0]) * (vy[0] - longint'(y)) - (vx[0] - longint'(x)) * (vy[1] - vy[0]);
        ey = (vx[0] - longint'(x)) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[0] - longint'(y));
        det = (vx[2] - vx[0]) * (vy[1] - vy[0]) - (vx[1] - vx[0]) * (vy[2] - vy[0]);
        if (det == 0) return f;
        n0 = det - ex - ey;
        n1 = ey;
        n2 = ex;
        if ((n0 != 0 && ((n0 < 0) != (det < 0))) || (n1 != 0 && ((n1 < 0) != (det < 0))) ||
            (n2 != 0 && ((n2 < 0) != (det < 0))))
            return f;
        z = lerp(n0, n1, n2, vz[0], vz[1], vz[2], det);
        if (z < -32768) z = -32768;
        if (z > 32767) z = 32767;
        f.cov = 1'b1;
        f.z = z[15:0];
        if (longint'(zbuf[a]) < z) begin
            zbuf[a] = shortint'(z);
            u = lerp(n0, n1, n2, vu[0], vu[1], vu[2], det);
            v = lerp(n0, n1, n2, vv[0], vv[1], vv[2], det);
            if (u < 0) u = 0;
            if (v < 0) v = 0;
            if (v > 4096) v = 4096;
            tx = (u * tex_w) >>> 12;
            ty = ((4096 - v) * tex_h) >>> 12;
            f.passed = 1'b1;
            f.tx = tx[12:0];
            f.ty = ty[12:0];
        end
        return f;
    endfunction

    task automatic write_reg(logic [tfdt_pkg::CFG_IDX_W-1:0] idx,
                             logic [tfdt_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tfdt_pkg::CFG_VPOS0, tfdt_pkg::CFG_VPOS1, tfdt_pkg::CFG_VPOS2:
                vpos[idx - tfdt_pkg::CFG_VPOS0] = data[39:0];
            tfdt_pkg::CFG_VTEX0, tfdt_pkg::CFG_VTEX1, tfdt_pkg::CFG_VTEX2:
                vtex[idx - tfdt_pkg::CFG_VTEX0] = data[23:0];
            tfdt_pkg::CFG_TEXW: tex_w = longint'(data[12:0]);
            tfdt_pkg::CFG_TEXH: tex_h = longint'(data[12:0]);
            default: ;
        endcase
    endtask

    task automatic send_pixel(logic o, logic [7:0] x, logic [7:0] y, bit blank_exp);
        t_frag f;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        op <= o;
        px <= x;
        py <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        f = shade_pixel(o, x, y);
        if (blank_exp) f = '{x, y, 1'b0, 1'b0, '0, '0, '0};
        if (o == tfdt_pkg::OP_CLEAR) n_clear++;
        frag_q.push_back(f);
    endtask

    // drop valid, let all results come back, then a short settle
    task automatic drain();
        in_valid <= 1'b0;
        while (frag_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(0, 340)) - 40;
    endfunction

    task automatic random_triangle();
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 5) == 0)
                write_reg(tfdt_pkg::CFG_VPOS0 + i[3:0], 40'({$urandom(), $urandom()}));
            else
                write_reg(tfdt_pkg::CFG_VPOS0 + i[3:0],
                          pack_pos(rand_coord(), rand_coord(), $urandom()));
            write_reg(tfdt_pkg::CFG_VTEX0 + i[3:0], 40'($urandom()));
        end
        case ($urandom_range(0, 2))
            0: write_reg(tfdt_pkg::CFG_TEXW, 40'(1));
            1: write_reg(tfdt_pkg::CFG_TEXW, 40'(4096));
            default: write_reg(tfdt_pkg::CFG_TEXW, 40'($urandom_range(1, 4096)));
        endcase
        case ($urandom_range(0, 2))
            0: write_reg(tfdt_pkg::CFG_TEXH, 40'(1));
            1: write_reg(tfdt_pkg::CFG_TEXH, 40'(4096));
            default: write_reg(tfdt_pkg::CFG_TEXH, 40'($urandom_range(1, 4096)));
        endcase
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_cfg(logic [tfdt_pkg::CFG_IDX_W-1:0] idx,
                                    logic [tfdt_pkg::CFG_DATA_W-1:0] d);
        rows.push_back('{ROW_CFG, idx, d, tfdt_pkg::OP_SHADE, 8'd0, 8'd0, 1'b0});
    endfunction

    function automatic void add_pix(logic o, int x, int y, bit blank_exp);
        rows.push_back('{ROW_PIX, '0, '0, o, x[7:0], y[7:0], blank_exp});
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (frag_q.size() == 0) begin
                $error("result for pixel (%0d,%0d) with none expected", o_out_x, o_out_y);
                errors++;
            end else begin
                t_frag e;
                e = frag_q.pop_front();
                n_seen++;
                if (e.cov) n_cov++;
                if (e.passed) n_pass++;
                if (o_out_x !== e.x) begin
                    $error("out_x: expected %0d, got %0d", e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y: expected %0d, got %0d", e.y, o_out_y);
                    errors++;
                end
                if (o_covered !== e.cov) begin
                    $error("covered: expected %0b, got %0b", e.cov, o_covered);
                    errors++;
                end
                if (o_depth_passed !== e.passed) begin
                    $error("depth_passed: expected %0b, got %0b", e.passed, o_depth_passed);
                    errors++;
                end
                if (o_fragment_depth !== e.z) begin
                    $error("fragment_depth: expected %0d, got %0d", e.z, o_fragment_depth);
                    errors++;
                end
                if (o_texel_x !== e.tx) begin
                    $error("texel_x: expected %0d, got %0d", e.tx, o_texel_x);
                    errors++;
                end
                if (o_texel_y !== e.ty) begin
                    $error("texel_y: expected %0d, got %0d", e.ty, o_texel_y);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [7:0] pool_x [8];
        logic [7:0] pool_y [8];
        bit         cfg_open;
        logic [2:0] k;
        errors = 0;
        n_cov = 0;
        n_pass = 0;
        n_clear = 0;
        n_seen = 0;
        idle_en = 1'b1;
        hold_pending = 1'b0;
        cfg_open = 1'b0;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = tfdt_pkg::OP_SHADE;
        px = '0;
        py = '0;
        for (int i = 0; i < 3; i++) begin
            vpos[i] = '0;
            vtex[i] = '0;
        end
        tex_w = 1024;
        tex_h = 1024;
        foreach (zbuf[i]) zbuf[i] = -32768;

        // all vertices at zero after reset: degenerate, nothing covered
        add_pix(tfdt_pkg::OP_SHADE, 0, 0, 1'b1);
        add_pix(tfdt_pkg::OP_SHADE, 255, 255, 1'b1);
        add_pix(tfdt_pkg::OP_CLEAR, 10, 10, 1'b1);
        // right triangle over the whole screen, depth extremes at the corners
        add_cfg(tfdt_pkg::CFG_VPOS0, pack_pos(0, 0, 32767));
        add_cfg(tfdt_pkg::CFG_VPOS1, pack_pos(0, 600, -32768));
        add_cfg(tfdt_pkg::CFG_VPOS2, pack_pos(600, 0, 0));
        add_cfg(tfdt_pkg::CFG_VTEX0, 40'({12'd0, 12'd0}));
        add_cfg(tfdt_pkg::CFG_VTEX1, 40'({12'd4095, 12'd0}));
        add_cfg(tfdt_pkg::CFG_VTEX2, 40'({12'd0, 12'd4095}));
        add_cfg(tfdt_pkg::CFG_TEXW, 40'(4096));
        add_cfg(tfdt_pkg::CFG_TEXH, 40'(1));
        add_pix(tfdt_pkg::OP_SHADE, 0, 0, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 255, 0, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 0, 255, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 100, 100, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 100, 100, 1'b0);
        add_pix(tfdt_pkg::OP_CLEAR, 100, 100, 1'b1);
        add_pix(tfdt_pkg::OP_SHADE, 100, 100, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 255, 255, 1'b0);
        // opposite winding, texture size at the other extreme
        add_cfg(tfdt_pkg::CFG_VPOS1, pack_pos(600, 0, 1000));
        add_cfg(tfdt_pkg::CFG_VPOS2, pack_pos(0, 600, -2000));
        add_cfg(tfdt_pkg::CFG_TEXW, 40'(1));
        add_cfg(tfdt_pkg::CFG_TEXH, 40'(4096));
        add_pix(tfdt_pkg::OP_SHADE, 1, 1, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 128, 7, 1'b0);
        add_pix(tfdt_pkg::OP_SHADE, 0, 0, 1'b0);
        add_pix(tfdt_pkg::OP_CLEAR, 0, 0, 1'b1);
        add_pix(tfdt_pkg::OP_SHADE, 0, 0, 1'b0);
        add_pix(tfdt_pkg::OP_CLEAR, 255, 255, 1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                if (!cfg_open) drain();
                cfg_open = 1'b1;
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                if (cfg_open) cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_pixel(rows[r].op, rows[r].x, rows[r].y, rows[r].blank_exp);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            random_triangle();
            if (ph == 5) idle_en = 1'b0;
            if (ph == 1) hold_pending = 1'b1;
            for (int i = 0; i < 8; i++) begin
                pool_x[i] = 8'($urandom());
                pool_y[i] = 8'($urandom());
            end
            for (int i = 0; i < 115; i++) begin
                k = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 1) == 0)
                    send_pixel($urandom_range(0, 9) == 0, pool_x[k], pool_y[k], 1'b0);
                else
                    send_pixel($urandom_range(0, 9) == 0, 8'($urandom()), 8'($urandom()),
                               1'b0);
            end
        end

        drain();
        $display("%0d pixels checked: %0d covered, %0d depth writes, %0d clears",
                 n_seen, n_cov, n_pass, n_clear);
        $display("random triangles and texture sizes over 6 phases, one long output stall");
        if (errors == 0 && frag_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
